FILE: rtl/cdm_pkg.sv
package cdm_pkg;

	// running energy sum width and delivered mean width
	localparam int ESUM_W = 40;
	localparam int MEAN_W = 32;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_LD_X,
		ST_LD_Y,
		ST_LD_ACC,
		ST_W_START,
		ST_PI_RD,
		ST_PI_LD,
		ST_PJ_RD,
		ST_PJ_DIF,
		ST_P_MX,
		ST_P_MY,
		ST_P_CMP,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_SQ1_GO,
		ST_SQ1_WAIT,
		ST_SQ2_GO,
		ST_SQ2_WAIT,
		ST_FIN
	} cdm_state_t;

	// start/done pair of an iterative unit
	typedef struct packed {
		logic start;
	} cdm_unit_req_t;

	typedef struct packed {
		logic done;
	} cdm_unit_rsp_t;

endpackage

FILE: rtl/constellation_distance_metrics_unit.sv
// Channel  | Ports                                   | Handshake
// ---------+-----------------------------------------+------------------------------------
// request  | x_coord, y_coord, last_point            | taken when start && !busy
// result   | mean_energy, min_dist_sq, max_dist_sq,  | valid for the single cycle done is
//          | min_dist, diameter_out, point_count,    | high; the receiver cannot stall
//          | too_few, overflowed                     |
//
// A stored point takes the request edge plus three squarer steps (LD_X, LD_Y, LD_ACC); a
// dropped point that is not the last, with the store full, leaves the sequencer idle. The last
// request then walks every pair through the one shared squarer, row by row (read, difference,
// two squares, compare), then runs the 40-step divider and two root passes of
// COORD_BITS+1 steps each.
// Reset clears the sequencer, the fill count, energy sum and drop flag; the point
// store needs no clearing since only entries below the fill count are read.
// busy stays high for the whole of a request's work; results are never held back.
module constellation_distance_metrics_unit #(
	parameter int MAX_POINTS = 256,
	parameter int COORD_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic signed [COORD_BITS-1:0]          x_coord,
	input  logic signed [COORD_BITS-1:0]          y_coord,
	input  logic                                  last_point,
	output logic                                  done,
	output logic [cdm_pkg::MEAN_W-1:0]            mean_energy,
	output logic [2*COORD_BITS:0]                 min_dist_sq,
	output logic [2*COORD_BITS:0]                 max_dist_sq,
	output logic [COORD_BITS:0]                   min_dist,
	output logic [COORD_BITS:0]                   diameter_out,
	output logic [$clog2(MAX_POINTS+1)-1:0]       point_count,
	output logic                                  too_few,
	output logic                                  overflowed
);
	import cdm_pkg::*;

	localparam int AW  = $clog2(MAX_POINTS);
	localparam int CW  = $clog2(MAX_POINTS + 1);
	localparam int OPW = COORD_BITS + 1;      // coordinate or coordinate difference
	localparam int SQW = 2 * COORD_BITS;      // one square
	localparam int DSW = 2 * COORD_BITS + 1;  // sum of two squares
	localparam int RTW = COORD_BITS + 1;      // root of DSW bits

	// sequencer
	cdm_state_t state_q, state_d;

	// control state
	logic [CW-1:0]     count_q;
	logic [ESUM_W-1:0] esum_q;
	logic              drop_q;
	logic              last_q;
	logic [CW-1:0]     i_q;
	logic [CW-1:0]     j_q;
	logic              first_q;
	logic              done_q;

	// datapath
	logic signed [OPW-1:0]    opa_q, opb_q;
	logic [COORD_BITS-1:0]    pix_q, piy_q;
	logic [DSW-1:0]           d_q;
	logic [DSW-1:0]           min_q, max_q;
	logic [RTW-1:0]           rmin_q;
	logic [2*COORD_BITS-1:0]  rd_q;
	logic [2*COORD_BITS-1:0]  mem_q [MAX_POINTS];

	// result registers
	logic [MEAN_W-1:0] res_mean_q;
	logic [DSW-1:0]    res_min_sq_q, res_max_sq_q;
	logic [RTW-1:0]    res_min_q, res_max_q;
	logic [CW-1:0]     res_cnt_q;
	logic              res_few_q, res_ovf_q;

	// combinational controls
	logic                  accept;
	logic                  full;
	logic                  mem_we;
	logic [AW-1:0]         rd_addr;
	logic signed [OPW-1:0] mul_op;
	cdm_unit_req_t         div_req, sqrt_req;
	cdm_unit_rsp_t         div_rsp, sqrt_rsp;
	logic [DSW-1:0]        sqrt_in;

	logic [SQW-1:0]        sq;
	logic [ESUM_W-1:0]     quotient;
	logic [RTW-1:0]        root;
	logic [DSW-1:0]        dcur;
	logic [CW:0]           j_next, i_plus2, n_ext;
	logic signed [OPW-1:0] rdx_ext, rdy_ext, pix_ext, piy_ext;

	assign accept  = start && !busy;
	assign full    = count_q >= CW'(MAX_POINTS);
	assign dcur    = d_q + DSW'(sq);
	assign j_next  = {1'b0, j_q} + (CW + 1)'(1);
	assign i_plus2 = {1'b0, i_q} + (CW + 1)'(2);
	assign n_ext   = {1'b0, count_q};

	assign rdx_ext = {rd_q[2*COORD_BITS-1], rd_q[2*COORD_BITS-1:COORD_BITS]};
	assign rdy_ext = {rd_q[COORD_BITS-1], rd_q[COORD_BITS-1:0]};
	assign pix_ext = {pix_q[COORD_BITS-1], pix_q};
	assign piy_ext = {piy_q[COORD_BITS-1], piy_q};

	// the one shared squarer: point energies and pair distances
	cdm_sqr #(.OPW(OPW)) u_sqr (
		.clk (clk),
		.op  (mul_op),
		.sq  (sq)
	);

	cdm_div #(.DVW(CW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.dividend (esum_q),
		.divisor  (count_q),
		.rsp      (div_rsp),
		.quotient (quotient)
	);

	cdm_isqrt #(.VW(DSW)) u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sqrt_req),
		.value  (sqrt_in),
		.rsp    (sqrt_rsp),
		.root   (root)
	);

	// point store, one write and one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[count_q[AW-1:0]] <= {x_coord, y_coord};
		end
		rd_q <= mem_q[rd_addr];
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (!full) begin
						state_d = ST_LD_X;
					end else if (last_point) begin
						state_d = ST_W_START;
					end
				end
			end
			ST_LD_X:   state_d = ST_LD_Y;
			ST_LD_Y:   state_d = ST_LD_ACC;
			ST_LD_ACC: state_d = last_q ? ST_W_START : ST_IDLE;
			ST_W_START: begin
				state_d = (count_q < CW'(2)) ? ST_DIV_GO : ST_PI_RD;
			end
			ST_PI_RD:  state_d = ST_PI_LD;
			ST_PI_LD:  state_d = ST_PJ_RD;
			ST_PJ_RD:  state_d = ST_PJ_DIF;
			ST_PJ_DIF: state_d = ST_P_MX;
			ST_P_MX:   state_d = ST_P_MY;
			ST_P_MY:   state_d = ST_P_CMP;
			ST_P_CMP: begin
				if (j_next < n_ext) begin
					state_d = ST_PJ_RD;
				end else if (i_plus2 < n_ext) begin
					state_d = ST_PI_RD;
				end else begin
					state_d = ST_DIV_GO;
				end
			end
			ST_DIV_GO:   state_d = ST_DIV_WAIT;
			ST_DIV_WAIT: state_d = div_rsp.done ? ST_SQ1_GO : ST_DIV_WAIT;
			ST_SQ1_GO:   state_d = ST_SQ1_WAIT;
			ST_SQ1_WAIT: state_d = sqrt_rsp.done ? ST_SQ2_GO : ST_SQ1_WAIT;
			ST_SQ2_GO:   state_d = ST_SQ2_WAIT;
			ST_SQ2_WAIT: state_d = sqrt_rsp.done ? ST_FIN : ST_SQ2_WAIT;
			ST_FIN:      state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		busy           = state_q != ST_IDLE;
		mem_we         = 1'b0;
		rd_addr        = j_q[AW-1:0];
		mul_op         = opa_q;
		div_req.start  = 1'b0;
		sqrt_req.start = 1'b0;
		sqrt_in        = min_q;
		case (state_q)
			ST_IDLE:   mem_we = start && !full;
			ST_PI_RD:  rd_addr = i_q[AW-1:0];
			ST_LD_Y,
			ST_P_MY:   mul_op = opb_q;
			ST_DIV_GO: div_req.start = 1'b1;
			ST_SQ1_GO: sqrt_req.start = 1'b1;
			ST_SQ2_GO: begin
				sqrt_req.start = 1'b1;
				sqrt_in        = max_q;
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			esum_q  <= '0;
			drop_q  <= 1'b0;
			last_q  <= 1'b0;
			i_q     <= '0;
			j_q     <= '0;
			first_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= state_q == ST_FIN;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						last_q <= last_point;
						if (full) begin
							drop_q <= 1'b1;
						end
					end
				end
				ST_LD_Y: esum_q <= esum_q + ESUM_W'(sq);
				ST_LD_ACC: begin
					esum_q  <= esum_q + ESUM_W'(sq);
					count_q <= count_q + CW'(1);
				end
				ST_W_START: begin
					i_q     <= '0;
					first_q <= 1'b1;
				end
				ST_PI_LD: j_q <= i_q + CW'(1);
				ST_P_CMP: begin
					first_q <= 1'b0;
					if (j_next < n_ext) begin
						j_q <= j_q + CW'(1);
					end else begin
						i_q <= i_q + CW'(1);
					end
				end
				ST_FIN: begin
					count_q <= '0;
					esum_q  <= '0;
					drop_q  <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					opa_q <= {x_coord[COORD_BITS-1], x_coord};
					opb_q <= {y_coord[COORD_BITS-1], y_coord};
				end
			end
			ST_W_START: begin
				// too-few sets report zero distances
				min_q <= '0;
				max_q <= '0;
			end
			ST_PI_LD: begin
				pix_q <= rd_q[2*COORD_BITS-1:COORD_BITS];
				piy_q <= rd_q[COORD_BITS-1:0];
			end
			ST_PJ_DIF: begin
				opa_q <= pix_ext - rdx_ext;
				opb_q <= piy_ext - rdy_ext;
			end
			ST_P_MY: d_q <= DSW'(sq);
			ST_P_CMP: begin
				if (first_q || dcur < min_q) begin
					min_q <= dcur;
				end
				if (first_q || dcur > max_q) begin
					max_q <= dcur;
				end
			end
			ST_SQ1_WAIT: begin
				if (sqrt_rsp.done) begin
					rmin_q <= root;
				end
			end
			ST_FIN: begin
				res_mean_q   <= (count_q == '0) ? '0 : quotient[MEAN_W-1:0];
				res_min_sq_q <= min_q;
				res_max_sq_q <= max_q;
				res_min_q    <= rmin_q;
				res_max_q    <= root;
				res_cnt_q    <= count_q;
				res_few_q    <= count_q < CW'(2);
				res_ovf_q    <= drop_q;
			end
			default: begin
			end
		endcase
	end

	assign done         = done_q;
	assign mean_energy  = res_mean_q;
	assign min_dist_sq  = res_min_sq_q;
	assign max_dist_sq  = res_max_sq_q;
	assign min_dist     = res_min_q;
	assign diameter_out = res_max_q;
	assign point_count  = res_cnt_q;
	assign too_few      = res_few_q;
	assign overflowed   = res_ovf_q;

endmodule

FILE: rtl/cdm_sqr.sv
module cdm_sqr #(
	parameter int OPW = 17
) (
	input  logic                      clk,
	input  logic signed [OPW-1:0]     op,
	output logic        [2*OPW-3:0]   sq
);
	import cdm_pkg::*;

	logic signed [2*OPW-1:0] prod;
	logic        [2*OPW-3:0] sq_q;

	// |op| < 2^(OPW-1), so the square fits 2*(OPW-1) bits
	assign prod = op * op;

	always_ff @(posedge clk) begin
		sq_q <= prod[2*OPW-3:0];
	end

	assign sq = sq_q;

endmodule

FILE: rtl/cdm_div.sv
module cdm_div #(
	parameter int DVW = 9
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cdm_pkg::cdm_unit_req_t      req,
	input  logic [cdm_pkg::ESUM_W-1:0]  dividend,
	input  logic [DVW-1:0]              divisor,
	output cdm_pkg::cdm_unit_rsp_t      rsp,
	output logic [cdm_pkg::ESUM_W-1:0]  quotient
);
	import cdm_pkg::*;

	localparam int CNTW = $clog2(ESUM_W + 1);

	logic            run_q;
	logic            done_q;
	logic [CNTW-1:0] cnt_q;
	logic [DVW:0]    rem_q;
	logic [ESUM_W-1:0] quo_q;
	logic [DVW-1:0]  dvs_q;
	logic [DVW:0]    rem_sh;
	logic            fits;

	// restoring division, one quotient bit a cycle
	assign rem_sh = {rem_q[DVW-1:0], quo_q[ESUM_W-1]};
	assign fits   = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + CNTW'(1);
				if (cnt_q == CNTW'(ESUM_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (run_q) begin
			rem_q <= fits ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
			quo_q <= {quo_q[ESUM_W-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign quotient = quo_q;

endmodule

FILE: rtl/cdm_isqrt.sv
module cdm_isqrt #(
	parameter int VW = 33
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cdm_pkg::cdm_unit_req_t  req,
	input  logic [VW-1:0]           value,
	output cdm_pkg::cdm_unit_rsp_t  rsp,
	output logic [(VW+1)/2-1:0]     root
);
	import cdm_pkg::*;

	localparam int RW   = (VW + 1) / 2;
	localparam int PW   = 2 * RW;
	localparam int CNTW = $clog2(RW + 1);

	logic            run_q;
	logic            done_q;
	logic [CNTW-1:0] cnt_q;
	logic [PW-1:0]   val_q;
	logic [RW+1:0]   rem_q;
	logic [RW-1:0]   root_q;
	logic [RW+3:0]   rem_sh;
	logic [RW+3:0]   trial;
	logic            fits;

	// digit-by-digit root, one result bit a cycle
	assign rem_sh = {rem_q, val_q[PW-1:PW-2]};
	assign trial  = (RW + 4)'({root_q, 2'b01});
	assign fits   = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + CNTW'(1);
				if (cnt_q == CNTW'(RW - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			val_q  <= PW'(value);
			rem_q  <= '0;
			root_q <= '0;
		end else if (run_q) begin
			val_q  <= {val_q[PW-3:0], 2'b00};
			rem_q  <= fits ? (RW + 2)'(rem_sh - trial) : (RW + 2)'(rem_sh);
			root_q <= {root_q[RW-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign root     = root_q;

endmodule

FILE: rtl/cdm_checker.sv
module cdm_checker #(
	parameter int MAX_POINTS = 256,
	parameter int COORD_BITS = 16
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            busy,
	input logic                            done,
	input logic [2*COORD_BITS:0]           min_dist_sq,
	input logic [2*COORD_BITS:0]           max_dist_sq,
	input logic [COORD_BITS:0]             min_dist,
	input logic [COORD_BITS:0]             diameter_out,
	input logic [$clog2(MAX_POINTS+1)-1:0] point_count,
	input logic                            too_few
);
	import cdm_pkg::*;

	// a result only appears once the unit has gone idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// each set runs the divider and both root passes, so results never come back to back
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for two cycles");

	a_few_count: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (too_few == (point_count < 2)))
		else $error("too_few disagrees with point_count");

	a_few_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && too_few |-> (min_dist_sq == 0) && (max_dist_sq == 0))
		else $error("distances not zero for a set of fewer than two points");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		done && !too_few |-> (min_dist_sq <= max_dist_sq) && (min_dist <= diameter_out))
		else $error("minimum exceeds maximum");

endmodule

bind constellation_distance_metrics_unit cdm_checker #(
	.MAX_POINTS (MAX_POINTS),
	.COORD_BITS (COORD_BITS)
) u_cdm_checker (.*);
